[design/cehs_pkg.sv]
`timescale 1ns / 1ps

package cehs_pkg;

    // Operation codes carried in the operation field.
    localparam logic OP_HIT = 1'b0;
    localparam logic OP_END = 1'b1;

    // Widths fixed by the input and output fields.
    localparam int TDC_BITS     = 5;
    localparam int WORD_BITS    = 8;
    localparam int HIT_TIME_BITS = 8;
    localparam int POS_BITS     = 7;
    localparam int CHAMBER_BITS = TDC_BITS - 2;
    localparam int INDEX_BITS   = 2;

    // Decoupling queue between the classifier and the hit store.
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

    // One classified transaction as it travels through the queue.
    typedef struct packed {
        logic                     is_end;
        logic [CHAMBER_BITS-1:0]  chamber;
        logic                     axis;
        logic [POS_BITS-1:0]      position;
        logic [HIT_TIME_BITS-1:0] hit_time;
    } t_entry;

endpackage

[design/cehs_front.sv]
`timescale 1ns / 1ps

module cehs_front #(
    parameter int NUM_CHAMBERS     = 4,
    parameter int CHANNELS_PER_TDC = 64
) (
    input  logic                                i_operation,
    input  logic [cehs_pkg::TDC_BITS-1:0]       i_tdc_number,
    input  logic [cehs_pkg::WORD_BITS-1:0]      i_channel_word,
    input  logic [cehs_pkg::HIT_TIME_BITS-1:0]  i_hit_time,
    output logic                                o_keep,
    output cehs_pkg::t_entry                    o_entry
);
    import cehs_pkg::*;

    localparam logic [POS_BITS-1:0]   PAIR_STEP = POS_BITS'(CHANNELS_PER_TDC % (1 << POS_BITS));
    localparam logic [TDC_BITS:0]     MAX_TDC   = (TDC_BITS + 1)'(4 * NUM_CHAMBERS);

    logic [TDC_BITS-1:0] tdc_m1;
    logic                in_range;
    logic [POS_BITS-1:0] channel;

    always_comb begin
        tdc_m1   = i_tdc_number - TDC_BITS'(1);
        in_range = (i_tdc_number != '0) && ({1'b0, i_tdc_number} <= MAX_TDC);
        channel  = POS_BITS'(i_channel_word >> 2);

        // Hits from a TDC outside the installed chambers are dropped here.
        o_keep = (i_operation == OP_END) || in_range;

        o_entry.is_end   = (i_operation == OP_END);
        o_entry.chamber  = tdc_m1[TDC_BITS-1:2];
        o_entry.axis     = tdc_m1[1];
        o_entry.position = channel + (tdc_m1[0] ? PAIR_STEP : '0);
        o_entry.hit_time = i_hit_time;
    end

endmodule

[design/cehs_queue.sv]
`timescale 1ns / 1ps

module cehs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cehs_pkg::t_entry i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_pop_valid,
    output cehs_pkg::t_entry o_pop_data
);
    import cehs_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [PTR_BITS:0]   r_count;
    logic [PTR_BITS:0]   n_count;

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + (PTR_BITS + 1)'(1);
            2'b01:   n_count = r_count - (PTR_BITS + 1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_full      = (r_count == (PTR_BITS + 1)'(QUEUE_DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd_ptr];

endmodule

[design/cehs_back.sv]
`timescale 1ns / 1ps

module cehs_back #(
    parameter int NUM_CHAMBERS = 4,
    parameter int TIME_BITS    = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_head_valid,
    input  cehs_pkg::t_entry                  i_head,
    output logic                              o_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [cehs_pkg::INDEX_BITS-1:0]   o_chamber_index,
    output logic [cehs_pkg::POS_BITS-1:0]     o_x_position,
    output logic                              o_x_found,
    output logic [cehs_pkg::POS_BITS-1:0]     o_y_position,
    output logic                              o_y_found,
    output logic                              o_last_chamber
);
    import cehs_pkg::*;

    localparam int CH_BITS = (NUM_CHAMBERS > 1) ? $clog2(NUM_CHAMBERS) : 1;
    localparam logic [CH_BITS-1:0] LAST_ROW = CH_BITS'(NUM_CHAMBERS - 1);

    // One row per chamber, holding the x and y slots side by side.
    logic [TIME_BITS-1:0] r_x_time [NUM_CHAMBERS];
    logic [TIME_BITS-1:0] r_y_time [NUM_CHAMBERS];
    logic [POS_BITS-1:0]  r_x_pos  [NUM_CHAMBERS];
    logic [POS_BITS-1:0]  r_y_pos  [NUM_CHAMBERS];
    logic [NUM_CHAMBERS-1:0] r_x_vld;
    logic [NUM_CHAMBERS-1:0] r_y_vld;

    logic [CH_BITS-1:0] r_emit_row;
    logic               r_out_valid;

    logic [CH_BITS-1:0]   row;
    logic                 out_free;
    logic                 do_hit;
    logic                 do_emit;
    logic [TIME_BITS-1:0] new_time;
    logic [TIME_BITS-1:0] old_time;
    logic                 old_vld;
    logic                 take;
    logic [CH_BITS:0]     emit_ext;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        do_hit   = i_head_valid && !i_head.is_end;
        do_emit  = i_head_valid && i_head.is_end && out_free;
        row      = i_head.is_end ? r_emit_row : i_head.chamber[CH_BITS-1:0];
        new_time = TIME_BITS'(i_head.hit_time);
        old_time = i_head.axis ? r_y_time[row] : r_x_time[row];
        old_vld  = i_head.axis ? r_y_vld[row]  : r_x_vld[row];
        take     = do_hit && (!old_vld || (new_time < old_time));
        o_pop    = do_hit || (do_emit && (r_emit_row == LAST_ROW));
        emit_ext = {1'b0, r_emit_row};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld     <= '0;
            r_y_vld     <= '0;
            r_emit_row  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                if (i_head.axis) begin
                    r_y_vld[row] <= 1'b1;
                end else begin
                    r_x_vld[row] <= 1'b1;
                end
            end
            if (do_emit) begin
                r_x_vld[row] <= 1'b0;
                r_y_vld[row] <= 1'b0;
                r_emit_row   <= (r_emit_row == LAST_ROW) ? '0 : r_emit_row + CH_BITS'(1);
            end
            if (out_free) begin
                r_out_valid <= do_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (i_head.axis) begin
                r_y_time[row] <= new_time;
                r_y_pos[row]  <= i_head.position;
            end else begin
                r_x_time[row] <= new_time;
                r_x_pos[row]  <= i_head.position;
            end
        end
        if (do_emit) begin
            o_chamber_index <= INDEX_BITS'(emit_ext);
            o_x_position    <= r_x_vld[row] ? r_x_pos[row] : '0;
            o_x_found       <= r_x_vld[row];
            o_y_position    <= r_y_vld[row] ? r_y_pos[row] : '0;
            o_y_found       <= r_y_vld[row];
            o_last_chamber  <= (r_emit_row == LAST_ROW);
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[design/chamber_earliest_hit_select_top.sv]
`timescale 1ns / 1ps

// Earliest-hit selector for wire chambers.
// Input channel (i_in_valid / o_in_stall): one transaction is either a TDC hit
// (operation 0) or an end-of-event marker (operation 1). Hits from TDCs that
// do not belong to an installed chamber are discarded at the input.
// Output channel (o_out_valid / i_out_stall): each end-of-event marker yields
// one transaction per chamber, chamber 0 first, with o_last_chamber set on the
// final one. A position reads as zero when its found flag is clear.
// Input transactions are taken one per cycle while the queue is not full; each hit
// is a compare and update of one chamber row in the hit store. An end-of-event
// marker occupies the store until it has emitted one result per chamber.
// With an empty queue ahead of it, an accepted marker passes through the queue
// and then the result register before its first result appears at the output;
// the remaining results follow in chamber order.
// A two-entry queue separates the classifier from the hit store, so input
// transactions keep flowing while the output is stalled until the queue fills.
// When the receiver stalls, the result register holds its transaction and
// emission pauses. Synchronous reset clears the queue, the output valid and
// every slot's found flag; no clearing pass is needed.
module chamber_earliest_hit_select_top #(
    parameter int NUM_CHAMBERS     = 4,
    parameter int CHANNELS_PER_TDC = 64,
    parameter int TIME_BITS        = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_operation,
    input  logic [cehs_pkg::TDC_BITS-1:0]       i_tdc_number,
    input  logic [cehs_pkg::WORD_BITS-1:0]      i_channel_word,
    input  logic [cehs_pkg::HIT_TIME_BITS-1:0]  i_hit_time,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [cehs_pkg::INDEX_BITS-1:0]     o_chamber_index,
    output logic [cehs_pkg::POS_BITS-1:0]       o_x_position,
    output logic                                o_x_found,
    output logic [cehs_pkg::POS_BITS-1:0]       o_y_position,
    output logic                                o_y_found,
    output logic                                o_last_chamber
);
    import cehs_pkg::*;

    logic   keep;
    logic   push;
    logic   full;
    logic   pop;
    logic   head_valid;
    t_entry entry;
    t_entry head;

    // The classifier is combinational; its decision is written to the queue
    // in the same cycle the transaction is accepted.
    cehs_front #(
        .NUM_CHAMBERS     (NUM_CHAMBERS),
        .CHANNELS_PER_TDC (CHANNELS_PER_TDC)
    ) u_front (
        .i_operation    (i_operation),
        .i_tdc_number   (i_tdc_number),
        .i_channel_word (i_channel_word),
        .i_hit_time     (i_hit_time),
        .o_keep         (keep),
        .o_entry        (entry)
    );

    assign o_in_stall = full;
    assign push       = i_in_valid && !full && keep;

    cehs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (entry),
        .o_full      (full),
        .i_pop       (pop),
        .o_pop_valid (head_valid),
        .o_pop_data  (head)
    );

    // The back end owns the hit store and the result register.
    cehs_back #(
        .NUM_CHAMBERS (NUM_CHAMBERS),
        .TIME_BITS    (TIME_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (head_valid),
        .i_head          (head),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_chamber_index (o_chamber_index),
        .o_x_position    (o_x_position),
        .o_x_found       (o_x_found),
        .o_y_position    (o_y_position),
        .o_y_found       (o_y_found),
        .o_last_chamber  (o_last_chamber)
    );

endmodule
